>>> rtl/sscko_pkg.sv
// ----------------------------------------------------------------------------
// sscko_pkg
// Shared types, constants and helpers for the scaled sprite color key overlay.
// ----------------------------------------------------------------------------
package sscko_pkg;

    localparam int SPRITE_SIDE = 256;
    localparam int CRD_W       = $clog2(SPRITE_SIDE);
    localparam int ADDR_W      = $clog2(SPRITE_SIDE * SPRITE_SIDE);
    localparam int SPRITE_DEPTH = SPRITE_SIDE * SPRITE_SIDE;

    localparam int RGB_W      = 24;
    localparam int POS_W      = 12;
    localparam int WIN_W      = 12;
    localparam int IMG_W      = 13;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = POS_W + STEP_W;
    localparam int SRC_W      = PROD_W - FRAC_W;
    localparam int ORG_W      = 14;
    localparam int LOC_W      = 15;
    localparam int CHAN_W     = 8;
    localparam int KEY_W      = 10;

    localparam int MARGIN     = 30;
    localparam int KEY_LEVEL  = 255;
    localparam int KEY_GAP    = 100;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int JOB_DEPTH  = 4;
    localparam int JPTR_W     = $clog2(JOB_DEPTH);
    localparam int OUT_DEPTH  = 4;
    localparam int OPTR_W     = $clog2(OUT_DEPTH);

    localparam logic [STEP_W-1:0] UNIT_STEP = STEP_W'(1 << FRAC_W);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CORNER        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP        = 3'd6;

    typedef struct packed {
        logic              req_type;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [RGB_W-1:0]  pixel_rgb;
    } t_item;

    typedef struct packed {
        logic [RGB_W-1:0]  out_rgb;
        logic              replaced;
    } t_result;

    typedef struct packed {
        logic [1:0]        corner;
        logic [WIN_W-1:0]  window_width;
        logic [WIN_W-1:0]  window_height;
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [RGB_W-1:0]  rgb;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_key_chan(input logic [CHAN_W-1:0] c);
        logic [KEY_W-1:0] v;
        v = KEY_W'(c);
        return (v > KEY_W'(KEY_LEVEL - KEY_GAP)) && (v < KEY_W'(KEY_LEVEL + KEY_GAP));
    endfunction

    function automatic logic is_key(input logic [RGB_W-1:0] p);
        return is_key_chan(p[7:0]) && is_key_chan(p[15:8]) && is_key_chan(p[23:16]);
    endfunction

    function automatic logic [CRD_W-1:0] sat_crd(input logic [SRC_W-1:0] s);
        logic [CRD_W-1:0] r;
        if (s > SRC_W'(SPRITE_SIDE - 1)) begin
            r = CRD_W'(SPRITE_SIDE - 1);
        end else begin
            r = CRD_W'(s);
        end
        return r;
    endfunction

endpackage

>>> rtl/sscko_ram.sv
// ----------------------------------------------------------------------------
// sscko_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sscko_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sscko_fifo.sv
// ----------------------------------------------------------------------------
// sscko_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sscko_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sscko_pkg::t_job   i_job,
    input  logic              i_pop,
    output sscko_pkg::t_job   o_head,
    output sscko_pkg::t_qstat o_stat
);
    import sscko_pkg::*;

    t_job              r_mem [JOB_DEPTH];
    logic [JPTR_W-1:0] r_wr;
    logic [JPTR_W-1:0] r_rd;
    logic [JPTR_W:0]   r_cnt;
    logic [JPTR_W-1:0] n_wr;
    logic [JPTR_W-1:0] n_rd;
    logic [JPTR_W:0]   n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == (JPTR_W+1)'(JOB_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == JPTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == JPTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> rtl/sscko_front.sv
// ----------------------------------------------------------------------------
// sscko_front
// Accept items, place the window, test membership and scale to sprite address.
// ----------------------------------------------------------------------------
module sscko_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sscko_pkg::t_cfg   i_cfg,
    input  logic              i_push,
    output logic              o_full,
    input  sscko_pkg::t_item  i_item,
    output logic              o_job_push,
    output sscko_pkg::t_job   o_job,
    input  sscko_pkg::t_qstat i_job_stat
);
    import sscko_pkg::*;

    logic signed [ORG_W-1:0] r_org_x;
    logic signed [ORG_W-1:0] r_org_y;
    logic signed [ORG_W-1:0] n_org_x;
    logic signed [ORG_W-1:0] n_org_y;

    logic                    r_a_v;
    t_item                   r_a;

    logic                    r_b_v;
    logic                    r_b_req;
    logic                    r_b_hit;
    logic [POS_W-1:0]        r_b_lx;
    logic [POS_W-1:0]        r_b_ly;
    logic [RGB_W-1:0]        r_b_rgb;
    logic                    n_b_hit;
    logic [POS_W-1:0]        n_b_lx;
    logic [POS_W-1:0]        n_b_ly;

    logic                    r_c_v;
    logic                    r_c_req;
    logic                    r_c_hit;
    logic [SRC_W-1:0]        r_c_sx;
    logic [SRC_W-1:0]        r_c_sy;
    logic [RGB_W-1:0]        r_c_rgb;

    logic signed [LOC_W-1:0] lx;
    logic signed [LOC_W-1:0] ly;
    logic                    in_win;
    logic                    in_sprite;
    logic [STEP_W-1:0]       step_x;
    logic [STEP_W-1:0]       step_y;
    logic [PROD_W-1:0]       prod_x;
    logic [PROD_W-1:0]       prod_y;
    logic [CRD_W-1:0]        sx;
    logic [CRD_W-1:0]        sy;
    logic                    en;

    assign n_org_x = i_cfg.corner[0]
        ? ORG_W'(i_cfg.image_width) - ORG_W'(i_cfg.window_width) - ORG_W'(MARGIN)
        : ORG_W'(MARGIN);
    assign n_org_y = i_cfg.corner[1]
        ? ORG_W'(i_cfg.image_height) - ORG_W'(i_cfg.window_height) - ORG_W'(MARGIN)
        : ORG_W'(MARGIN);

    always_ff @(posedge i_clk) begin
        r_org_x <= n_org_x;
        r_org_y <= n_org_y;
    end

    assign en         = !r_c_v || !i_job_stat.full;
    assign o_full     = !en;
    assign o_job_push = r_c_v && !i_job_stat.full;

    always_comb begin
        lx = $signed({{(LOC_W-POS_W){1'b0}}, r_a.pos_x}) - LOC_W'(r_org_x);
        ly = $signed({{(LOC_W-POS_W){1'b0}}, r_a.pos_y}) - LOC_W'(r_org_y);
        in_win = !lx[LOC_W-1] && !ly[LOC_W-1]
            && ($unsigned(lx) < LOC_W'(i_cfg.window_width))
            && ($unsigned(ly) < LOC_W'(i_cfg.window_height));
        in_sprite = (r_a.pos_x < POS_W'(SPRITE_SIDE)) && (r_a.pos_y < POS_W'(SPRITE_SIDE));
        if (r_a.req_type == REQ_LOAD) begin
            n_b_hit = in_sprite;
            n_b_lx  = r_a.pos_x;
            n_b_ly  = r_a.pos_y;
        end else begin
            n_b_hit = in_win;
            n_b_lx  = POS_W'($unsigned(lx));
            n_b_ly  = POS_W'($unsigned(ly));
        end
    end

    assign step_x = (r_b_req == REQ_LOAD) ? UNIT_STEP : i_cfg.x_step;
    assign step_y = (r_b_req == REQ_LOAD) ? UNIT_STEP : i_cfg.y_step;
    assign prod_x = PROD_W'(r_b_lx) * PROD_W'(step_x);
    assign prod_y = PROD_W'(r_b_ly) * PROD_W'(step_y);

    assign sx = sat_crd(r_c_sx);
    assign sy = sat_crd(r_c_sy);

    assign o_job.req_type = r_c_req;
    assign o_job.hit      = r_c_hit;
    assign o_job.addr     = ADDR_W'(sy) * ADDR_W'(SPRITE_SIDE) + ADDR_W'(sx);
    assign o_job.rgb      = r_c_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_push;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= i_item;
            r_b_req <= r_a.req_type;
            r_b_hit <= n_b_hit;
            r_b_lx  <= n_b_lx;
            r_b_ly  <= n_b_ly;
            r_b_rgb <= r_a.pixel_rgb;
            r_c_req <= r_b_req;
            r_c_hit <= r_b_hit;
            r_c_sx  <= prod_x[PROD_W-1:FRAC_W];
            r_c_sy  <= prod_y[PROD_W-1:FRAC_W];
            r_c_rgb <= r_b_rgb;
        end
    end

endmodule

>>> rtl/sscko_back.sv
// ----------------------------------------------------------------------------
// sscko_back
// Write sprite pixels, read and key sprite pixels, queue results.
// ----------------------------------------------------------------------------
module sscko_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sscko_pkg::t_job   i_job,
    input  sscko_pkg::t_qstat i_job_stat,
    output logic              o_job_pop,
    output sscko_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import sscko_pkg::*;

    logic              r_r_v;
    logic              r_r_hit;
    logic [RGB_W-1:0]  r_r_rgb;

    t_result           r_q [OUT_DEPTH];
    logic [OPTR_W-1:0] r_wr;
    logic [OPTR_W-1:0] r_rd;
    logic [OPTR_W:0]   r_cnt;
    logic [OPTR_W-1:0] n_wr;
    logic [OPTR_W-1:0] n_rd;
    logic [OPTR_W:0]   n_cnt;

    logic              room;
    logic              is_load;
    logic              ram_we;
    logic              ram_re;
    logic [RGB_W-1:0]  sp;
    logic              repl;
    t_result           res;
    logic              q_pop;

    assign room    = ((OPTR_W+1)'(r_cnt) + (OPTR_W+1)'(r_r_v)) < (OPTR_W+1)'(OUT_DEPTH);
    assign is_load = (i_job.req_type == REQ_LOAD);

    assign o_job_pop = !i_job_stat.empty && (is_load || room);
    assign ram_we    = o_job_pop && is_load && i_job.hit;
    assign ram_re    = o_job_pop && !is_load;

    sscko_ram #(
        .DATA_W (RGB_W),
        .DEPTH  (SPRITE_DEPTH)
    ) u_sprite (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_job.addr),
        .i_wdata (i_job.rgb),
        .i_re    (ram_re),
        .i_raddr (i_job.addr),
        .o_rdata (sp)
    );

    assign repl         = r_r_hit && !is_key(sp);
    assign res.out_rgb  = repl ? sp : r_r_rgb;
    assign res.replaced = repl;

    assign o_empty  = (r_cnt == '0);
    assign o_result = r_q[r_rd];
    assign q_pop    = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (r_r_v) begin
            n_wr = (r_wr == OPTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (q_pop) begin
            n_rd = (r_rd == OPTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (r_r_v && !q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (q_pop && !r_r_v) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_r_v <= ram_re;
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_r_hit <= i_job.hit;
            r_r_rgb <= i_job.rgb;
        end
        if (r_r_v) begin
            r_q[r_wr] <= res;
        end
    end

endmodule

>>> rtl/scaled_sprite_color_key_overlay.sv
// ----------------------------------------------------------------------------
// scaled_sprite_color_key_overlay
// Nearest-neighbor scaled sprite overlay with a near-white color key.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------
//  item in   | push / full             | i_item   (t_item)
//  result    | empty / pop             | o_result (t_result)
//  config    | i_cfg_we, i_cfg_idx     | i_cfg_data
//
//  One item per cycle sustained while full stays low; a background pixel passes
//  through three front stages, the job queue, the registered sprite RAM read and
//  the result queue before it shows on o_result. Loads give no result.
//  Reset is synchronous and active low; sprite contents are kept as is.
//  full rises only when the last front stage holds an item and the job queue
//  is full; the back part stops popping pixel jobs when the result queue has
//  no room, while loads keep draining.
// ----------------------------------------------------------------------------
module scaled_sprite_color_key_overlay (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  sscko_pkg::t_item                        i_item,
    output logic                                    empty,
    input  logic                                    pop,
    output sscko_pkg::t_result                      o_result,
    input  logic                                    i_cfg_we,
    input  logic [sscko_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [sscko_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sscko_pkg::*;

    t_cfg   r_cfg;
    t_job   job_in;
    t_job   job_head;
    t_qstat job_stat;
    logic   job_push;
    logic   job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.corner        <= 2'd0;
            r_cfg.window_width  <= WIN_W'(1);
            r_cfg.window_height <= WIN_W'(1);
            r_cfg.image_width   <= IMG_W'(4096);
            r_cfg.image_height  <= IMG_W'(4096);
            r_cfg.x_step        <= UNIT_STEP;
            r_cfg.y_step        <= UNIT_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORNER:        r_cfg.corner        <= i_cfg_data[1:0];
                CFG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg_data[WIN_W-1:0];
                CFG_WINDOW_HEIGHT: r_cfg.window_height <= i_cfg_data[WIN_W-1:0];
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[IMG_W-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data[IMG_W-1:0];
                CFG_X_STEP:        r_cfg.x_step        <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:        r_cfg.y_step        <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sscko_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_stat (job_stat)
    );

    sscko_fifo u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_stat  (job_stat)
    );

    sscko_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_head),
        .i_job_stat (job_stat),
        .o_job_pop  (job_pop),
        .o_result   (o_result),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    a_job_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_stat.full)
        else $error("job pushed into a full queue");

    a_job_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_stat.empty)
        else $error("job popped from an empty queue");

    a_full_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !job_stat.full |-> !full)
        else $error("input stalled while job queue has room");

endmodule
